### src/loop_closure_pose_matcher_core_defines.svh
// Assertion macros shared by the pose matcher RTL
`ifndef LOOP_CLOSURE_POSE_MATCHER_CORE_DEFINES_SVH
`define LOOP_CLOSURE_POSE_MATCHER_CORE_DEFINES_SVH

// Check that a condition implies a consequence on the same edge
`define LCPM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcpm check failed");

// Check that a condition implies a consequence on the next edge
`define LCPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcpm check failed");

`endif

### src/lcpm_pkg.sv
package lcpm_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int MAX_REPORTS_DEF = 63;

    localparam logic [23:0] DIST_LIMIT_RST  = 24'd500;
    localparam logic [14:0] ANGLE_LIMIT_RST = 15'd3000;
    localparam logic [31:0] MIN_GAP_RST     = 32'd30000;

    localparam logic signed [17:0] HALF_TURN = 18'sd18000;
    localparam logic signed [17:0] FULL_TURN = 18'sd36000;

    localparam logic [1:0] CFG_DIST_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_ANGLE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_MIN_GAP     = 2'd2;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_DETECT = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [31:0]       stamp;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] heading;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  match_index;
        logic [24:0] distance;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NEWEST,
        ST_READ,
        ST_GAP,
        ST_SQX,
        ST_SQY,
        ST_SQZ,
        ST_CMP,
        ST_SQRT,
        ST_EMIT,
        ST_LAST,
        ST_NONE
    } state_t;

endpackage

### src/loop_closure_pose_matcher_core.sv
// Add request: written into the pose memory at the accepting edge, no result; ready stays high.
// Detect: fetch the newest time, then for each stored pose but the newest: read it, test the gap,
//   and if it holds, square and sum the axis differences, then test distance and heading; on a
//   match, take the root (shared square unit, 26-step root). Each match word is held until the next
//   one is found or the scan ends. One request at a time: ready stays low until the scan is done.
// Reset: asynchronous active low; clears pose count, oldest slot, limits to defaults.
`include "loop_closure_pose_matcher_core_defines.svh"

module loop_closure_pose_matcher_core #(
    parameter int DEPTH       = lcpm_pkg::DEPTH_DEF,
    parameter int MAX_REPORTS = lcpm_pkg::MAX_REPORTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lcpm_pkg::req_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lcpm_pkg::rsp_t     out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = $clog2(MAX_REPORTS + 1);

    // configuration
    logic [23:0] dist_limit_reg;
    logic [14:0] angle_limit_reg;
    logic [31:0] min_gap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_limit_reg  <= lcpm_pkg::DIST_LIMIT_RST;
            angle_limit_reg <= lcpm_pkg::ANGLE_LIMIT_RST;
            min_gap_reg     <= lcpm_pkg::MIN_GAP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lcpm_pkg::CFG_DIST_LIMIT:  dist_limit_reg  <= cfg_data[23:0];
                lcpm_pkg::CFG_ANGLE_LIMIT: angle_limit_reg <= cfg_data[14:0];
                lcpm_pkg::CFG_MIN_GAP:     min_gap_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // pose memory
    logic [31:0]        time_mem [DEPTH];
    logic signed [23:0] x_mem    [DEPTH];
    logic signed [23:0] y_mem    [DEPTH];
    logic signed [23:0] z_mem    [DEPTH];
    logic signed [15:0] hd_mem   [DEPTH];

    lcpm_pkg::state_t state_reg, state_next;
    logic [AW-1:0] oldest_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [RW-1:0] nrep_reg, nrep_next;
    lcpm_pkg::req_t q_reg;
    logic [31:0]    newest_reg;
    logic [31:0]        rd_time_reg;
    logic signed [23:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic signed [15:0] rd_hd_reg;
    logic [50:0]    d2_reg, d2_next;
    logic [50:0]    rem_reg, rem_next;
    logic [25:0]    root_reg, root_next;
    logic [4:0]     sq_step_reg, sq_step_next;
    logic [5:0]     pend_idx_reg, pend_idx_next;
    logic [24:0]    pend_dist_reg, pend_dist_next;
    lcpm_pkg::rsp_t out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    logic in_fire;
    assign in_fire = in_valid && in_ready;
    assign in_ready = (state_reg == lcpm_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // output register can take a word; a first match needs no slot
    logic slot_free;
    logic emit_go;
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_go   = (nrep_reg == '0) || slot_free;

    // address computation
    logic [AW:0]   rd_sum;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   wr_sum;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] rd_off;
    logic          full;

    assign full = (count_reg == CW'(DEPTH));
    always_comb
    begin
        rd_off = (state_reg == lcpm_pkg::ST_NEWEST) ? (count_reg - 1'b1) : idx_reg;
        rd_sum = {1'b0, oldest_reg} + (AW+1)'(rd_off);
        rd_addr = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH)) : rd_sum[AW-1:0];
        wr_sum = {1'b0, oldest_reg} + (AW+1)'(count_reg);
        if (full)
            wr_addr = oldest_reg;
        else
            wr_addr = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH))
                                                 : wr_sum[AW-1:0];
    end

    // write and read the pose memory
    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.req_type == lcpm_pkg::REQ_ADD)
        begin
            time_mem[wr_addr] <= in_data.stamp;
            x_mem[wr_addr]    <= in_data.pos_x;
            y_mem[wr_addr]    <= in_data.pos_y;
            z_mem[wr_addr]    <= in_data.pos_z;
            hd_mem[wr_addr]   <= in_data.heading;
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_x_reg    <= x_mem[rd_addr];
        rd_y_reg    <= y_mem[rd_addr];
        rd_z_reg    <= z_mem[rd_addr];
        rd_hd_reg   <= hd_mem[rd_addr];
    end

    // history pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            count_reg  <= '0;
        end
        else if (in_fire && in_data.req_type == lcpm_pkg::REQ_ADD)
        begin
            if (full)
                oldest_reg <= (oldest_reg == AW'(DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
            else
                count_reg <= count_reg + 1'b1;
        end
    end

    // shared multiplier: squares one axis difference
    logic signed [24:0] mul_a;
    logic [24:0]        mul_abs;
    logic [49:0]        mul_p;
    always_comb
    begin
        case (state_reg)
            lcpm_pkg::ST_SQX: mul_a = 25'(q_reg.pos_x) - 25'(rd_x_reg);
            lcpm_pkg::ST_SQY: mul_a = 25'(q_reg.pos_y) - 25'(rd_y_reg);
            lcpm_pkg::ST_SQZ: mul_a = 25'(q_reg.pos_z) - 25'(rd_z_reg);
            default:          mul_a = '0;
        endcase
        mul_abs = mul_a[24] ? 25'(-mul_a) : mul_a;
        mul_p   = 50'(mul_abs) * 50'(mul_abs);
    end

    // gap and heading tests
    logic signed [32:0] gap;
    logic signed [17:0] dh;
    logic [17:0]        dh_abs;
    logic [47:0]        lim2;
    logic               ang_ok;
    logic               cmp_ok;
    always_comb
    begin
        gap = $signed({1'b0, newest_reg}) - $signed({1'b0, rd_time_reg});
        dh  = 18'(q_reg.heading) - 18'(rd_hd_reg);
        if (dh > lcpm_pkg::HALF_TURN)
            dh = dh - lcpm_pkg::FULL_TURN;
        else if (dh < -lcpm_pkg::HALF_TURN)
            dh = dh + lcpm_pkg::FULL_TURN;
        // second pass brings out-of-range headings into the half turn
        if (dh > lcpm_pkg::HALF_TURN)
            dh = dh - lcpm_pkg::FULL_TURN;
        else if (dh < -lcpm_pkg::HALF_TURN)
            dh = dh + lcpm_pkg::FULL_TURN;
        dh_abs = dh[17] ? 18'(-dh) : dh;
        ang_ok = dh_abs <= 18'(angle_limit_reg);
        lim2   = 48'(dist_limit_reg) * 48'(dist_limit_reg);
        cmp_ok = (d2_reg <= 51'(lim2)) && ang_ok;
    end

    // square root step
    logic [51:0] trial;
    always_comb
    begin
        trial = {1'b0, rem_reg} - ({24'b0, root_reg, 2'b01} << (2 * sq_step_reg));
    end

    // next state
    logic last_idx;
    assign last_idx = (idx_reg + 1'b1 >= count_reg - 1'b1);
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcpm_pkg::ST_IDLE:
                if (in_fire && in_data.req_type == lcpm_pkg::REQ_DETECT)
                    state_next = (count_reg > CW'(1)) ? lcpm_pkg::ST_NEWEST
                                                       : lcpm_pkg::ST_NONE;
            lcpm_pkg::ST_NEWEST: state_next = lcpm_pkg::ST_READ;
            lcpm_pkg::ST_READ:   state_next = lcpm_pkg::ST_GAP;
            lcpm_pkg::ST_GAP:
                if (gap >= $signed({1'b0, min_gap_reg}))
                    state_next = lcpm_pkg::ST_SQX;
                else
                    state_next = last_idx ? (nrep_reg == '0 ? lcpm_pkg::ST_NONE
                                                             : lcpm_pkg::ST_LAST)
                                          : lcpm_pkg::ST_READ;
            lcpm_pkg::ST_SQX: state_next = lcpm_pkg::ST_SQY;
            lcpm_pkg::ST_SQY: state_next = lcpm_pkg::ST_SQZ;
            lcpm_pkg::ST_SQZ: state_next = lcpm_pkg::ST_CMP;
            lcpm_pkg::ST_CMP:
                if (cmp_ok)
                    state_next = lcpm_pkg::ST_SQRT;
                else
                    state_next = last_idx ? (nrep_reg == '0 ? lcpm_pkg::ST_NONE
                                                             : lcpm_pkg::ST_LAST)
                                          : lcpm_pkg::ST_READ;
            lcpm_pkg::ST_SQRT:
                if (sq_step_reg == '0)
                    state_next = lcpm_pkg::ST_EMIT;
            lcpm_pkg::ST_EMIT:
                if (emit_go)
                begin
                    if (last_idx || (nrep_reg + 1'b1 == RW'(MAX_REPORTS)))
                        state_next = lcpm_pkg::ST_LAST;
                    else
                        state_next = lcpm_pkg::ST_READ;
                end
            lcpm_pkg::ST_LAST:
                if (slot_free)
                    state_next = lcpm_pkg::ST_IDLE;
            lcpm_pkg::ST_NONE:
                if (slot_free)
                    state_next = lcpm_pkg::ST_IDLE;
            default: state_next = lcpm_pkg::ST_IDLE;
        endcase
    end

    // datapath updates and output word; hold each match until the next one shows up or the scan ends
    always_comb
    begin
        idx_next       = idx_reg;
        nrep_next      = nrep_reg;
        d2_next        = d2_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        sq_step_next   = sq_step_reg;
        pend_idx_next  = pend_idx_reg;
        pend_dist_next = pend_dist_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            lcpm_pkg::ST_IDLE:
            begin
                idx_next  = '0;
                nrep_next = '0;
            end
            lcpm_pkg::ST_GAP:
                if (gap < $signed({1'b0, min_gap_reg}))
                    idx_next = idx_reg + 1'b1;
            lcpm_pkg::ST_SQX: d2_next = 51'(mul_p);
            lcpm_pkg::ST_SQY: d2_next = d2_reg + 51'(mul_p);
            lcpm_pkg::ST_SQZ: d2_next = d2_reg + 51'(mul_p);
            lcpm_pkg::ST_CMP:
            begin
                rem_next     = d2_reg;
                root_next    = '0;
                sq_step_next = 5'd25;
                if (!cmp_ok)
                    idx_next = idx_reg + 1'b1;
            end
            lcpm_pkg::ST_SQRT:
            begin
                if (!trial[51])
                begin
                    rem_next  = trial[50:0];
                    root_next = {root_reg[24:0], 1'b1};
                end
                else
                    root_next = {root_reg[24:0], 1'b0};
                if (sq_step_reg != '0)
                    sq_step_next = sq_step_reg - 1'b1;
            end
            lcpm_pkg::ST_EMIT:
                if (emit_go)
                begin
                    // release the held match, keep the new one
                    if (nrep_reg != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{found: 1'b1, match_index: pend_idx_reg,
                                           distance: pend_dist_reg, last: 1'b0};
                    end
                    pend_idx_next  = 6'(idx_reg);
                    pend_dist_next = root_reg[24:0];
                    nrep_next      = nrep_reg + 1'b1;
                    idx_next       = idx_reg + 1'b1;
                end
            lcpm_pkg::ST_LAST:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{found: 1'b1, match_index: pend_idx_reg,
                                       distance: pend_dist_reg, last: 1'b1};
                end
            lcpm_pkg::ST_NONE:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{found: 1'b0, match_index: '0, distance: '0, last: 1'b1};
                end
            default: ;
        endcase
    end

    // control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcpm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sq_step_reg   <= '0;
            idx_reg       <= '0;
            nrep_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sq_step_reg   <= sq_step_next;
            idx_reg       <= idx_next;
            nrep_reg      <= nrep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            q_reg <= in_data;
        if (state_reg == lcpm_pkg::ST_READ && idx_reg == '0)
            newest_reg <= rd_time_reg;
        d2_reg        <= d2_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        pend_idx_reg  <= pend_idx_next;
        pend_dist_reg <= pend_dist_next;
        out_reg       <= out_next;
    end

    // checks
    `LCPM_ASSERT_IMP(a_busy_no_accept, state_reg != lcpm_pkg::ST_IDLE, !in_ready)
    `LCPM_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(DEPTH))
    `LCPM_ASSERT_NEXT(a_last_word, state_reg == lcpm_pkg::ST_LAST && slot_free, out_valid_reg)
    `LCPM_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg)
    `LCPM_ASSERT_IMP(a_reports_bound, 1'b1, nrep_reg <= RW'(MAX_REPORTS))

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HIST_DEPTH  = lcpm_pkg::DEPTH_DEF;
    localparam int REPORT_CAP  = lcpm_pkg::MAX_REPORTS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int RX_HOLD_LEN = 400;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    lcpm_pkg::req_t in_data;
    logic           out_valid;
    logic           out_ready;
    lcpm_pkg::rsp_t out_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [31:0]    cfg_data;

    // shadow of the pose history and limits
    logic [31:0]        hist_stamp [HIST_DEPTH];
    logic signed [23:0] hist_x [HIST_DEPTH];
    logic signed [23:0] hist_y [HIST_DEPTH];
    logic signed [23:0] hist_z [HIST_DEPTH];
    logic signed [15:0] hist_head [HIST_DEPTH];
    int                 hist_oldest;
    int                 hist_count;
    logic [23:0]        dist_limit;
    logic [14:0]        angle_limit;
    logic [31:0]        gap_limit;

    lcpm_pkg::rsp_t match_q[$];
    int   fail_count;
    int   idle_cycles;
    int   words_sent;
    int   words_seen;
    int   detects_sent;
    bit   hold_rx;
    int   rx_hold_cycles;
    bit   rx_gaps_on;
    logic [31:0] stamp_now;

    loop_closure_pose_matcher_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // update the history or work out the matches of one request
    function automatic void predict_request(input lcpm_pkg::req_t r);
        int             slot;
        int             found_n;
        longint         newest;
        longint         gap;
        longint         dx;
        longint         dy;
        longint         dz;
        logic [63:0]    d2;
        logic [63:0]    lim2;
        int             dh;
        lcpm_pkg::rsp_t m;
        if (r.req_type == lcpm_pkg::REQ_ADD)
        begin
            if (hist_count >= HIST_DEPTH)
            begin
                slot        = hist_oldest;
                hist_oldest = (hist_oldest + 1) % HIST_DEPTH;
            end
            else
            begin
                slot       = (hist_oldest + hist_count) % HIST_DEPTH;
                hist_count = hist_count + 1;
            end
            hist_stamp[slot] = r.stamp;
            hist_x[slot]     = r.pos_x;
            hist_y[slot]     = r.pos_y;
            hist_z[slot]     = r.pos_z;
            hist_head[slot]  = r.heading;
            return;
        end
        found_n = 0;
        if (hist_count > 1)
        begin
            newest = longint'(hist_stamp[(hist_oldest + hist_count - 1) % HIST_DEPTH]);
            lim2   = 64'(dist_limit) * 64'(dist_limit);
            for (int i = 0; i + 1 < hist_count && found_n < REPORT_CAP; i++)
            begin
                slot = (hist_oldest + i) % HIST_DEPTH;
                gap  = newest - longint'(hist_stamp[slot]);
                if (gap < longint'(gap_limit))
                    continue;
                dx = longint'(r.pos_x) - longint'(hist_x[slot]);
                dy = longint'(r.pos_y) - longint'(hist_y[slot]);
                dz = longint'(r.pos_z) - longint'(hist_z[slot]);
                d2 = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
                if (d2 > lim2)
                    continue;
                dh = int'(r.heading) - int'(hist_head[slot]);
                while (dh > 18000)
                    dh = dh - 36000;
                while (dh < -18000)
                    dh = dh + 36000;
                if (dh < 0)
                    dh = -dh;
                if (dh > int'(angle_limit))
                    continue;
                m.found       = 1'b1;
                m.match_index = 6'(i);
                m.distance    = 25'(int_sqrt(d2));
                m.last        = 1'b0;
                match_q.push_back(m);
                found_n++;
            end
        end
        if (found_n == 0)
        begin
            m = '0;
            m.last = 1'b1;
            match_q.push_back(m);
        end
        else
            match_q[$].last = 1'b1;
    endfunction

    task automatic idle_gap(input bit allow_long);
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
        if (allow_long && $urandom_range(0, 19) == 0)
            n = $urandom_range(20, 60);
        repeat (n) @(negedge clk);
    endtask

    // send one request word and hold it until taken
    task automatic send_word(input lcpm_pkg::req_t r, input bit gaps);
        if (gaps)
            idle_gap(1'b1);
        in_data  = r;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(r);
        words_sent++;
        if (r.req_type == lcpm_pkg::REQ_DETECT)
            detects_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == lcpm_pkg::CFG_DIST_LIMIT)
            dist_limit = val[23:0];
        else if (idx == lcpm_pkg::CFG_ANGLE_LIMIT)
            angle_limit = val[14:0];
        else if (idx == lcpm_pkg::CFG_MIN_GAP)
            gap_limit = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait for all results, then let the block settle
    task automatic drain_results();
        while (match_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic lcpm_pkg::req_t make_pose(input logic [31:0] st, input int x,
                                                 input int y, input int z, input int h);
        lcpm_pkg::req_t r;
        r.req_type = lcpm_pkg::REQ_ADD;
        r.stamp    = st;
        r.pos_x    = 24'(x);
        r.pos_y    = 24'(y);
        r.pos_z    = 24'(z);
        r.heading  = 16'(h);
        return r;
    endfunction

    function automatic lcpm_pkg::req_t make_query(input int x, input int y, input int z,
                                                  input int h);
        lcpm_pkg::req_t r;
        r          = make_pose($urandom, x, y, z, h);
        r.req_type = lcpm_pkg::REQ_DETECT;
        return r;
    endfunction

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (match_q.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, out_data);
                fail_count++;
            end
            else if (out_data !== match_q[0])
            begin
                $display("%0t: mismatch expected %p actual %p", $time, match_q[0], out_data);
                fail_count++;
                void'(match_q.pop_front());
            end
            else
                void'(match_q.pop_front());
        end
    end

    // receiver stalls; a forced hold-off is counted here and ends on its own
    always @(negedge clk)
    begin
        if (hold_rx && rx_hold_cycles < RX_HOLD_LEN)
        begin
            out_ready <= 1'b0;
            rx_hold_cycles++;
        end
        else if (rx_gaps_on)
            out_ready <= ($urandom_range(0, 9) < 7);
        else
            out_ready <= 1'b1;
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || (!in_valid && !cfg_valid && match_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        stamp_now = 32'd1000;
        // empty and single-pose history
        send_word(make_query(0, 0, 0, 0), 1'b0);
        send_word(make_pose(stamp_now, 0, 0, 0, 0), 1'b0);
        send_word(make_query(0, 0, 0, 0), 1'b0);
        // extremes of position and heading
        send_word(make_pose(32'd0, 8388607, -8388608, 8388607, 18000), 1'b0);
        send_word(make_pose(32'hFFFF_FFFF, -8388608, 8388607, -8388608, -18000), 1'b0);
        send_word(make_pose(32'd40000, 100, 200, 300, -17900), 1'b0);
        send_word(make_pose(32'd90000, 0, 0, 0, 0), 1'b0);
        send_word(make_query(100, 250, 300, 17900), 1'b0);
        send_word(make_query(-8388608, -8388608, -8388608, -18000), 1'b0);
        // out-of-range headings wrap
        send_word(make_pose(32'd95000, 0, 0, 0, 32767), 1'b0);
        send_word(make_query(0, 0, 0, -32768), 1'b0);
        drain_results();
        // wide-open limits, max distance
        write_reg(lcpm_pkg::CFG_DIST_LIMIT, 32'hFF_FFFF);
        write_reg(lcpm_pkg::CFG_ANGLE_LIMIT, 32'h7FFF);
        write_reg(lcpm_pkg::CFG_MIN_GAP, 32'd0);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        send_word(make_query(8388607, 8388607, 8388607, 0), 1'b0);
        send_word(make_query(0, 0, 0, 0), 1'b0);
        drain_results();
        write_reg(lcpm_pkg::CFG_MIN_GAP, 32'hFFFF_FFFF);
        write_reg(lcpm_pkg::CFG_DIST_LIMIT, 32'd0);
        write_reg(lcpm_pkg::CFG_ANGLE_LIMIT, 32'd0);
        send_word(make_query(0, 0, 0, 0), 1'b0);
        drain_results();
    endtask

    // fill the history past its depth and hit the report cap
    task automatic test_wrap_and_cap();
        write_reg(lcpm_pkg::CFG_DIST_LIMIT, 32'd1000);
        write_reg(lcpm_pkg::CFG_ANGLE_LIMIT, 32'd18000);
        write_reg(lcpm_pkg::CFG_MIN_GAP, 32'd0);
        for (int i = 0; i < 70; i++)
            send_word(make_pose(32'd200000 + i, $urandom_range(0, 50), 0, 0,
                                $urandom_range(0, 36000) - 18000), 1'b1);
        send_word(make_query(10, 5, 0, 0), 1'b1);
        drain_results();
    endtask

    // receiver holds off long while requests keep coming
    task automatic test_backpressure();
        rx_hold_cycles = 0;
        hold_rx        = 1'b1;
        for (int i = 0; i < 4; i++)
            send_word(make_query($urandom_range(0, 40), 0, 0, 0), 1'b0);
        wait (rx_hold_cycles >= RX_HOLD_LEN);
        hold_rx = 1'b0;
        drain_results();
    endtask

    // mostly plausible trajectories with some wild poses
    task automatic test_random(input int n_items);
        int           x;
        int           y;
        int           mode;
        logic [127:0] wild;
        x = 0;
        y = 0;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 60 == 59)
            begin
                drain_results();
                mode = $urandom_range(0, 2);
                write_reg(lcpm_pkg::CFG_DIST_LIMIT,
                          mode == 0 ? 32'd500 : $urandom_range(50, 3000));
                write_reg(lcpm_pkg::CFG_ANGLE_LIMIT,
                          mode == 1 ? 32'd3000 : $urandom_range(0, 20000));
                write_reg(lcpm_pkg::CFG_MIN_GAP,
                          mode == 2 ? 32'd30000 : $urandom_range(0, 60000));
            end
            x = x + $urandom_range(0, 400) - 200;
            y = y + $urandom_range(0, 400) - 200;
            stamp_now = stamp_now + $urandom_range(0, 5000);
            if ($urandom_range(0, 9) < 6)
                send_word(make_pose(stamp_now, x, y, $urandom_range(0, 100),
                                    $urandom_range(0, 36000) - 18000), 1'b1);
            else if ($urandom_range(0, 9) < 8)
                send_word(make_query(x + $urandom_range(0, 600) - 300, y, 50,
                                     $urandom_range(0, 36000) - 18000), 1'b1);
            else
            begin
                wild = {$urandom, $urandom, $urandom, $urandom};
                send_word(lcpm_pkg::req_t'(wild[$bits(lcpm_pkg::req_t)-1:0]), 1'b1);
            end
        end
        drain_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        hold_rx        = 1'b0;
        rx_gaps_on     = 1'b0;
        rx_hold_cycles = 0;
        fail_count     = 0;
        idle_cycles    = 0;
        words_sent     = 0;
        words_seen     = 0;
        detects_sent   = 0;
        hist_oldest    = 0;
        hist_count     = 0;
        dist_limit     = lcpm_pkg::DIST_LIMIT_RST;
        angle_limit    = lcpm_pkg::ANGLE_LIMIT_RST;
        gap_limit      = lcpm_pkg::MIN_GAP_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        rx_gaps_on = 1'b1;
        test_wrap_and_cap();
        test_backpressure();
        test_random(120);

        $display("Sent %0d request words (%0d detects), checked %0d result words.",
                 words_sent, detects_sent, words_seen);
        $display("Covered wraparound, report cap, limit extremes and output stalls.");
        if (fail_count == 0 && match_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
